>>> rtl/qsfc_pkg.sv
`default_nettype none
package qsfc_pkg;

  localparam int FRAME_BYTES    = 16;
  localparam int CRC_BYTES      = 10;
  localparam int STORED_BYTES   = 12;
  localparam int POS_W          = 4;
  localparam int LSN_W          = 20;
  localparam int SUM_W          = LSN_W + 1;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int FRAMES_PER_SEC = 75;
  localparam int FRAMES_PER_MIN = 4500;
  localparam int PREGAP_FRAMES  = 150;
  localparam int WRAP_MINUTES   = 90;
  localparam int WRAP_FRAMES    = 450000;

  localparam int BYTE_CTL_ADR = 0;
  localparam int BYTE_TRACK   = 1;
  localparam int BYTE_INDEX   = 2;
  localparam int BYTE_REL_M   = 3;
  localparam int BYTE_REL_S   = 4;
  localparam int BYTE_REL_F   = 5;
  localparam int BYTE_ABS_M   = 7;
  localparam int BYTE_ABS_S   = 8;
  localparam int BYTE_ABS_F   = 9;
  localparam int BYTE_CRC_HI  = 10;
  localparam int BYTE_CRC_LO  = 11;

  typedef logic [7:0] byte_t;
  typedef byte_t frame_store_t [STORED_BYTES];

  typedef struct packed {
    logic        last;
    logic [15:0] crc;
  } frame_stat_t;

  typedef struct packed {
    logic                    crc_ok;
    logic [1:0]              q_mode;
    logic [3:0]              ctl_bits;
    logic [6:0]              track_no;
    logic [6:0]              index_no;
    logic signed [LSN_W-1:0] relative_lsn;
    logic signed [LSN_W-1:0] absolute_lsn;
    logic                    bcd_error;
    logic                    psc_bit;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] bcd_value(input byte_t b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  function automatic logic bcd_bad(input byte_t b);
    return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
  endfunction

  function automatic logic [LSN_W-1:0] msf_lsn(input byte_t m, input byte_t s,
                                                input byte_t f);
    logic [7:0]       mi;
    logic [SUM_W-1:0] sum;
    mi  = bcd_value(m);
    sum = SUM_W'(mi) * SUM_W'(FRAMES_PER_MIN)
        + SUM_W'(bcd_value(s)) * SUM_W'(FRAMES_PER_SEC)
        + SUM_W'(bcd_value(f)) - SUM_W'(PREGAP_FRAMES);
    if (mi >= 8'(WRAP_MINUTES)) begin
      sum = sum - SUM_W'(WRAP_FRAMES);
    end
    return sum[LSN_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/qsfc_frame.sv
`default_nettype none
module qsfc_frame
  import qsfc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire byte_t  q_byte,
  input  wire logic   frame_start,
  output frame_stat_t stat,
  output frame_store_t bytes
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      crc_accumulator, crc_accumulator_next;
  logic             frame_active, frame_active_next;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_eff;
  logic             active_eff;
  logic             last;

  assign active_eff = frame_start | frame_active;
  assign pos_eff    = frame_start ? '0 : byte_position;
  assign crc_eff    = frame_start ? '0 : crc_accumulator;
  assign last       = active_eff && (pos_eff >= POS_W'(FRAME_BYTES - 1));

  always_comb begin
    byte_position_next   = byte_position;
    crc_accumulator_next = crc_accumulator;
    frame_active_next    = frame_active;
    if (accept && active_eff) begin
      crc_accumulator_next = crc_eff;
      if (pos_eff < POS_W'(CRC_BYTES)) begin
        crc_accumulator_next = crc_update(crc_eff, q_byte);
      end
      if (last) begin
        frame_active_next  = 1'b0;
        byte_position_next = '0;
      end else begin
        frame_active_next  = 1'b1;
        byte_position_next = pos_eff + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_accumulator <= '0;
      frame_active    <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      crc_accumulator <= crc_accumulator_next;
      frame_active    <= frame_active_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORED_BYTES; i++) begin
      if (accept && active_eff && pos_eff == POS_W'(i)) begin
        bytes[i] <= q_byte;
      end
    end
  end

  assign stat.last = last;
  assign stat.crc  = crc_accumulator;

endmodule
`default_nettype wire

>>> rtl/qsfc_decode.sv
`default_nettype none
module qsfc_decode
  import qsfc_pkg::*;
(
  input  wire frame_store_t bytes,
  input  wire logic [15:0]  crc,
  input  wire logic         psc,
  output result_t           res
);

  logic       err;
  logic [3:0] adr;
  logic [7:0] track, index;

  assign adr   = bytes[BYTE_CTL_ADR][3:0];
  assign track = bcd_value(bytes[BYTE_TRACK]);
  assign index = bcd_value(bytes[BYTE_INDEX]);
  assign err   = bcd_bad(bytes[BYTE_TRACK]) | bcd_bad(bytes[BYTE_INDEX])
               | bcd_bad(bytes[BYTE_REL_M]) | bcd_bad(bytes[BYTE_REL_S])
               | bcd_bad(bytes[BYTE_REL_F]) | bcd_bad(bytes[BYTE_ABS_M])
               | bcd_bad(bytes[BYTE_ABS_S]) | bcd_bad(bytes[BYTE_ABS_F]);

  always_comb begin
    res.crc_ok   = (crc == ~{bytes[BYTE_CRC_HI], bytes[BYTE_CRC_LO]});
    res.q_mode   = (adr >= 4'd1 && adr <= 4'd3) ? adr[1:0] : 2'd0;
    res.ctl_bits = bytes[BYTE_CTL_ADR][7:4];
    res.bcd_error = err;
    res.psc_bit  = psc;
    if (err) begin
      res.track_no     = '0;
      res.index_no     = '0;
      res.relative_lsn = '0;
      res.absolute_lsn = '0;
    end else begin
      res.track_no     = track[6:0];
      res.index_no     = index[6:0];
      res.relative_lsn = msf_lsn(bytes[BYTE_REL_M], bytes[BYTE_REL_S], bytes[BYTE_REL_F]);
      res.absolute_lsn = msf_lsn(bytes[BYTE_ABS_M], bytes[BYTE_ABS_S], bytes[BYTE_ABS_F]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/q_subcode_frame_check_decode.sv
// Q subchannel frame checker: takes one byte per beat, frame_start marking byte 0,
// and gives one result beat on the last byte of each 16-byte frame (CRC-16/CCITT
// check over bytes 0..9, CTL/ADR, BCD track/index, relative and absolute LSN).
// Bytes before a frame start or after a complete frame are dropped. One byte is
// taken every cycle; the result register holds one result, and only a frame's
// last byte waits on in_stall while an earlier result is still stalled.
// The result is registered and is valid in the cycle after the last byte is taken.
`default_nettype none
module q_subcode_frame_check_decode
  import qsfc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              q_byte,
  input  wire logic                    frame_start,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         crc_ok,
  output logic [1:0]                   q_mode,
  output logic [3:0]                   ctl_bits,
  output logic [6:0]                   track_no,
  output logic [6:0]                   index_no,
  output logic signed [LSN_W-1:0]      relative_lsn,
  output logic signed [LSN_W-1:0]      absolute_lsn,
  output logic                         bcd_error,
  output logic                         psc_bit
);

  frame_stat_t  stat;
  frame_store_t bytes;
  result_t      res, result;
  logic         accept, load;

  assign in_stall = out_valid & out_stall & stat.last;
  assign accept   = in_valid & ~in_stall;
  assign load     = accept & stat.last;

  qsfc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .q_byte      (q_byte),
    .frame_start (frame_start),
    .stat        (stat),
    .bytes       (bytes)
  );

  qsfc_decode u_decode (
    .bytes (bytes),
    .crc   (stat.crc),
    .psc   (q_byte[0]),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

  assign crc_ok       = result.crc_ok;
  assign q_mode       = result.q_mode;
  assign ctl_bits     = result.ctl_bits;
  assign track_no     = result.track_no;
  assign index_no     = result.index_no;
  assign relative_lsn = result.relative_lsn;
  assign absolute_lsn = result.absolute_lsn;
  assign bcd_error    = result.bcd_error;
  assign psc_bit      = result.psc_bit;

endmodule
`default_nettype wire

>>> rtl/qsfc_checker.sv
`default_nettype none
module qsfc_checker
  import qsfc_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    crc_ok,
  input wire logic [1:0]              q_mode,
  input wire logic [3:0]              ctl_bits,
  input wire logic [6:0]              track_no,
  input wire logic [6:0]              index_no,
  input wire logic signed [LSN_W-1:0] relative_lsn,
  input wire logic signed [LSN_W-1:0] absolute_lsn,
  input wire logic                    bcd_error,
  input wire logic                    psc_bit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({crc_ok, q_mode, ctl_bits,
      track_no, index_no, relative_lsn, absolute_lsn, bcd_error, psc_bit}))
    else $error("stalled result beat changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result beat without an accepted byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");

  a_bcd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bcd_error |-> track_no == 7'd0 && index_no == 7'd0
      && relative_lsn == '0 && absolute_lsn == '0)
    else $error("decoded fields not cleared on BCD error");

  a_bcd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bcd_error |-> track_no <= 7'd99 && index_no <= 7'd99)
    else $error("track or index out of range");

endmodule

bind q_subcode_frame_check_decode qsfc_checker u_qsfc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .crc_ok       (crc_ok),
  .q_mode       (q_mode),
  .ctl_bits     (ctl_bits),
  .track_no     (track_no),
  .index_no     (index_no),
  .relative_lsn (relative_lsn),
  .absolute_lsn (absolute_lsn),
  .bcd_error    (bcd_error),
  .psc_bit      (psc_bit)
);
`default_nettype wire

>>> tb/tb_q_subcode_frame_check_decode.sv
`default_nettype none
module tb_q_subcode_frame_check_decode;
  import qsfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTE_TARGET = 1900;

  typedef byte_t frame_t [FRAME_BYTES];
  typedef enum int {K_GOOD, K_MESSY, K_CUT, K_STRAY, K_NOISE} stim_kind_e;

  class frame_scoreboard;
    logic [POS_W-1:0] pos;
    logic [15:0]      crc;
    byte_t            frame_buf [STORED_BYTES];
    logic             active;
    result_t          want_q [$];
    int               errors;
    int               taken;

    function new();
      pos = '0;
      crc = '0;
      active = 1'b0;
      errors = 0;
      taken = 0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, byte_t b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function int bcd_dec(byte_t b, inout logic bad);
      if (b[7:4] > 4'd9 || b[3:0] > 4'd9) bad = 1'b1;
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int msf_to_lsn(byte_t m, byte_t s, byte_t f, inout logic bad);
      int mi;
      int v;
      mi = bcd_dec(m, bad);
      v = mi * FRAMES_PER_MIN + bcd_dec(s, bad) * FRAMES_PER_SEC + bcd_dec(f, bad)
          - PREGAP_FRAMES;
      if (mi >= WRAP_MINUTES) v = v - WRAP_FRAMES;
      return v;
    endfunction

    function void note_byte(byte_t b, logic s);
      result_t    w;
      logic       bad;
      int         trk;
      int         idx;
      int         rel;
      int         absl;
      logic [3:0] adr;
      taken++;
      if (s) begin
        pos = '0;
        crc = '0;
        active = 1'b1;
      end
      if (!active) return;
      if (pos < STORED_BYTES) frame_buf[pos] = b;
      if (pos < CRC_BYTES) crc = crc_step(crc, b);
      if (pos < FRAME_BYTES - 1) begin
        pos = pos + POS_W'(1);
        return;
      end
      bad = 1'b0;
      trk = bcd_dec(frame_buf[BYTE_TRACK], bad);
      idx = bcd_dec(frame_buf[BYTE_INDEX], bad);
      rel = msf_to_lsn(frame_buf[BYTE_REL_M], frame_buf[BYTE_REL_S], frame_buf[BYTE_REL_F], bad);
      absl = msf_to_lsn(frame_buf[BYTE_ABS_M], frame_buf[BYTE_ABS_S], frame_buf[BYTE_ABS_F],
                        bad);
      adr = frame_buf[BYTE_CTL_ADR][3:0];
      w.crc_ok = (crc == ~{frame_buf[BYTE_CRC_HI], frame_buf[BYTE_CRC_LO]});
      w.q_mode = (adr >= 4'd1 && adr <= 4'd3) ? adr[1:0] : 2'd0;
      w.ctl_bits = frame_buf[BYTE_CTL_ADR][7:4];
      w.track_no = bad ? 7'd0 : trk[6:0];
      w.index_no = bad ? 7'd0 : idx[6:0];
      w.relative_lsn = bad ? '0 : rel[LSN_W-1:0];
      w.absolute_lsn = bad ? '0 : absl[LSN_W-1:0];
      w.bcd_error = bad;
      w.psc_bit = b[0];
      want_q.push_back(w);
      active = 1'b0;
      pos = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(result_t got);
      result_t w;
      if (want_q.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      w = want_q.pop_front();
      if (got.crc_ok !== w.crc_ok)
        report($sformatf("crc_ok got %0d want %0d", got.crc_ok, w.crc_ok));
      if (got.q_mode !== w.q_mode)
        report($sformatf("q_mode got %0d want %0d", got.q_mode, w.q_mode));
      if (got.ctl_bits !== w.ctl_bits)
        report($sformatf("ctl_bits got %h want %h", got.ctl_bits, w.ctl_bits));
      if (got.track_no !== w.track_no)
        report($sformatf("track_no got %0d want %0d", got.track_no, w.track_no));
      if (got.index_no !== w.index_no)
        report($sformatf("index_no got %0d want %0d", got.index_no, w.index_no));
      if (got.relative_lsn !== w.relative_lsn)
        report($sformatf("relative_lsn got %0d want %0d", got.relative_lsn, w.relative_lsn));
      if (got.absolute_lsn !== w.absolute_lsn)
        report($sformatf("absolute_lsn got %0d want %0d", got.absolute_lsn, w.absolute_lsn));
      if (got.bcd_error !== w.bcd_error)
        report($sformatf("bcd_error got %0d want %0d", got.bcd_error, w.bcd_error));
      if (got.psc_bit !== w.psc_bit)
        report($sformatf("psc_bit got %0d want %0d", got.psc_bit, w.psc_bit));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] q_byte = 8'h00;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic crc_ok;
  logic [1:0] q_mode;
  logic [3:0] ctl_bits;
  logic [6:0] track_no;
  logic [6:0] index_no;
  logic signed [LSN_W-1:0] relative_lsn;
  logic signed [LSN_W-1:0] absolute_lsn;
  logic bcd_error;
  logic psc_bit;

  frame_scoreboard sb;
  result_t seen;
  int cyc = 0;
  int burst_left = 0;
  bit quiet_run = 1'b0;

  q_subcode_frame_check_decode u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .q_byte(q_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .crc_ok(crc_ok),
    .q_mode(q_mode),
    .ctl_bits(ctl_bits),
    .track_no(track_no),
    .index_no(index_no),
    .relative_lsn(relative_lsn),
    .absolute_lsn(absolute_lsn),
    .bcd_error(bcd_error),
    .psc_bit(psc_bit)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc++;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(q_byte, frame_start);
      if (out_valid && !out_stall) begin
        seen.crc_ok = crc_ok;
        seen.q_mode = q_mode;
        seen.ctl_bits = ctl_bits;
        seen.track_no = track_no;
        seen.index_no = index_no;
        seen.relative_lsn = relative_lsn;
        seen.absolute_lsn = absolute_lsn;
        seen.bcd_error = bcd_error;
        seen.psc_bit = psc_bit;
        sb.check_result(seen);
      end
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure: free, random, long runs, alternate
  always @(negedge clk) begin
    case ((cyc / 250) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((cyc % 37) < 20);
      default: out_stall <= cyc[0];
    endcase
  end

  task idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      q_byte <= 8'($urandom);
      frame_start <= 1'($urandom);
    end
  endtask

  task send_byte(byte_t b, logic s);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) quiet_run = ~quiet_run;
      idle(quiet_run ? 0 : $urandom_range(1, 7));
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    q_byte <= b;
    frame_start <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic byte_t to_bcd(int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic int pick_num(int top);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic int pick_minute();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return WRAP_MINUTES - 1;
      2: return WRAP_MINUTES;
      3: return 99;
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  function automatic void fix_crc(inout frame_t fr);
    logic [15:0] c;
    c = '0;
    for (int i = 0; i < CRC_BYTES; i++) c = frame_scoreboard::crc_step(c, fr[i]);
    fr[BYTE_CRC_HI] = ~c[15:8];
    fr[BYTE_CRC_LO] = ~c[7:0];
  endfunction

  function automatic void make_frame(output frame_t fr, input bit clean);
    foreach (fr[i]) fr[i] = 8'($urandom);
    fr[BYTE_TRACK] = to_bcd(pick_num(99));
    fr[BYTE_INDEX] = to_bcd(pick_num(99));
    fr[BYTE_REL_M] = to_bcd(pick_minute());
    fr[BYTE_REL_S] = to_bcd(pick_num(99));
    fr[BYTE_REL_F] = to_bcd(pick_num(99));
    fr[BYTE_ABS_M] = to_bcd(pick_minute());
    fr[BYTE_ABS_S] = to_bcd(pick_num(99));
    fr[BYTE_ABS_F] = to_bcd(pick_num(99));
    if (!clean) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0: fr[BYTE_TRACK] = 8'($urandom);
          1: fr[BYTE_INDEX] = 8'($urandom);
          2: fr[BYTE_REL_M] = 8'($urandom);
          3: fr[BYTE_REL_S] = 8'($urandom);
          4: fr[BYTE_REL_F] = 8'($urandom);
          5: fr[BYTE_ABS_M] = 8'($urandom);
          6: fr[BYTE_ABS_S] = 8'($urandom);
          default: fr[BYTE_ABS_F] = 8'($urandom);
        endcase
      end
    end
    fix_crc(fr);
    if ($urandom_range(0, 9) == 0)
      fr[$urandom_range(0, BYTE_CRC_LO)][$urandom_range(0, 7)] ^= 1'b1;
  endfunction

  task send_frame(frame_t fr, int n);
    for (int i = 0; i < n; i++) send_byte(fr[i], i == 0);
  endtask

  initial begin
    frame_t fr;
    stim_kind_e kind;
    int r;
    int last_drain;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray bytes before any frame start
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);

    // all-zero time codes, minimum values
    make_frame(fr, 1'b1);
    fr[BYTE_CTL_ADR] = 8'h01;
    for (int i = BYTE_TRACK; i <= BYTE_ABS_F; i++) fr[i] = 8'h00;
    fr[FRAME_BYTES-1] = 8'h01;
    fix_crc(fr);
    send_frame(fr, FRAME_BYTES);

    // maxima, relative past the wrap, absolute right on it
    fr[BYTE_CTL_ADR] = 8'hF2;
    fr[BYTE_TRACK] = 8'h99;
    fr[BYTE_INDEX] = 8'h99;
    fr[BYTE_REL_M] = 8'h99;
    fr[BYTE_REL_S] = 8'h99;
    fr[BYTE_REL_F] = 8'h99;
    fr[BYTE_ABS_M] = 8'h90;
    fr[BYTE_ABS_S] = 8'h00;
    fr[BYTE_ABS_F] = 8'h00;
    fr[FRAME_BYTES-1] = 8'hFE;
    fix_crc(fr);
    send_frame(fr, FRAME_BYTES);

    // bytes after a completed frame are dropped
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);

    // restart mid frame, then BCD error with bad CRC and unknown mode
    send_frame(fr, 7);
    fr[BYTE_CTL_ADR] = 8'h40;
    fr[BYTE_TRACK] = 8'h9A;
    fr[BYTE_REL_M] = 8'h89;
    fix_crc(fr);
    fr[BYTE_CRC_LO] = ~fr[BYTE_CRC_LO];
    send_frame(fr, FRAME_BYTES);

    // ADR 15, last minute before the wrap, mode 3
    fr[BYTE_CTL_ADR] = 8'h0F;
    fr[BYTE_TRACK] = 8'h01;
    fr[BYTE_ABS_M] = 8'h89;
    fr[BYTE_ABS_S] = 8'h99;
    fr[BYTE_ABS_F] = 8'h99;
    fix_crc(fr);
    send_frame(fr, FRAME_BYTES);
    fr[BYTE_CTL_ADR] = 8'hB3;
    fix_crc(fr);
    send_frame(fr, FRAME_BYTES);

    drain_results();
    last_drain = sb.taken;

    while (sb.taken < BYTE_TARGET) begin
      if (sb.taken - last_drain > 500) begin
        drain_results();
        last_drain = sb.taken;
      end
      r = $urandom_range(0, 99);
      kind = (r < 62) ? K_GOOD : (r < 74) ? K_MESSY : (r < 84) ? K_CUT :
             (r < 92) ? K_STRAY : K_NOISE;
      case (kind)
        K_GOOD: begin
          make_frame(fr, 1'b1);
          send_frame(fr, FRAME_BYTES);
        end
        K_MESSY: begin
          make_frame(fr, 1'b0);
          send_frame(fr, FRAME_BYTES);
        end
        K_CUT: begin
          make_frame(fr, 1'b1);
          send_frame(fr, $urandom_range(1, FRAME_BYTES - 1));
        end
        K_STRAY: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        default: repeat ($urandom_range(4, 20))
          send_byte(8'($urandom), $urandom_range(0, 11) == 0);
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
